// File: sv/crc_cg_pkg.sv
// Package: shared constants and register codes for the CRC codeword generator.
package crc_cg_pkg;

  // Widths of the configuration registers
  localparam int POLY_W     = 31;
  localparam int LEN_W      = 6;
  localparam int LEN_EXT_W  = LEN_W + 1;
  localparam int CFG_DATA_W = POLY_W;
  localparam int CFG_IDX_W  = 1;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GEN_POLY = 1'b0,
    REG_GEN_LEN  = 1'b1
  } cfg_reg_t;

  // Generator length after reset
  localparam logic [LEN_W-1:0] GEN_LEN_RESET = LEN_W'(2);

endpackage

// File: sv/crc_cg_if.sv
// Interfaces: input bit channel and output codeword channel.
interface crc_cg_in_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic msg_last;

  modport source (output valid, output data_bit, output msg_last, input ready);
  modport sink (input valid, input data_bit, input msg_last, output ready);
endinterface

interface crc_cg_out_if;
  logic valid;
  logic ready;
  logic code_bit;
  logic is_check;
  logic code_last;

  modport source (output valid, output code_bit, output is_check, output code_last,
                  input ready);
  modport sink (input valid, input code_bit, input is_check, input code_last,
                output ready);
endinterface

// File: sv/crc_cg_fifo.sv
// Two-entry queue between the front (division) and back (serializer) parts.
module crc_cg_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  logic [W-1:0] entries [2];
  logic         wp;
  logic         rp;
  logic [1:0]   count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = entries[rp];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/crc_cg_front.sv
// Front part: configuration registers, running remainder, job push into the queue.
module crc_cg_front import crc_cg_pkg::*; #(
  parameter int MAX_GEN_LEN = 32,
  localparam int RW = MAX_GEN_LEN - 1,
  localparam int CW = $clog2(MAX_GEN_LEN),
  localparam int JW = RW + CW + 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  crc_cg_in_if.sink             bit_in,
  output logic                  push,
  output logic [JW-1:0]         push_data,
  input  logic                  full
);

  localparam int IW = (RW > 1) ? $clog2(RW) : 1;

  logic [POLY_W-1:0]    gen_poly;
  logic [LEN_W-1:0]     gen_length;
  logic [RW-1:0]        remainder;

  logic [LEN_EXT_W-1:0] len_ext;
  logic [LEN_EXT_W-1:0] len_c;
  logic [CW-1:0]        r;
  logic [RW-1:0]        mask;
  logic [RW-1:0]        poly_m;
  logic [RW-1:0]        rem_m;
  logic [RW-1:0]        rem_next;
  logic                 fb;
  logic                 accept;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_poly   <= '0;
      gen_length <= GEN_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_GEN_POLY: gen_poly   <= cfg_data;
        REG_GEN_LEN:  gen_length <= LEN_W'(cfg_data);
        default:      gen_poly   <= gen_poly;
      endcase
    end
  end

  // Check width from the clamped generator length
  always_comb begin
    len_ext = {1'b0, gen_length};
    if (len_ext < LEN_EXT_W'(2)) begin
      len_c = LEN_EXT_W'(2);
    end else if (len_ext > LEN_EXT_W'(MAX_GEN_LEN)) begin
      len_c = LEN_EXT_W'(MAX_GEN_LEN);
    end else begin
      len_c = len_ext;
    end
    r = CW'(len_c - LEN_EXT_W'(1));
  end

  // One step of the long division
  always_comb begin
    for (int i = 0; i < RW; i++) begin
      mask[i] = (i < int'(r));
    end
    poly_m   = RW'(gen_poly) & mask;
    rem_m    = remainder & mask;
    fb       = rem_m[IW'(r - CW'(1))] ^ bit_in.data_bit;
    rem_next = ((rem_m << 1) & mask) ^ (fb ? poly_m : '0);
  end

  assign bit_in.ready = ~full;
  assign accept       = bit_in.valid & ~full;
  assign push         = accept;
  assign push_data    = {bit_in.data_bit, bit_in.msg_last, r, rem_next};

  // Remainder update; cleared after the final message bit
  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= '0;
    end else if (accept) begin
      remainder <= bit_in.msg_last ? '0 : rem_next;
    end
  end

endmodule

// File: sv/crc_cg_back.sv
// Back part: pops jobs, echoes message bits and shifts out the check bits.
module crc_cg_back #(
  parameter int MAX_GEN_LEN = 32,
  localparam int RW = MAX_GEN_LEN - 1,
  localparam int CW = $clog2(MAX_GEN_LEN),
  localparam int JW = RW + CW + 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [JW-1:0] job,
  input  logic          empty,
  output logic          pop,
  crc_cg_out_if.source  code_out
);

  logic          job_bit;
  logic          job_last;
  logic [CW-1:0] job_r;
  logic [RW-1:0] job_rem;

  logic          out_valid, out_valid_next;
  logic          out_bit, out_bit_next;
  logic          out_check, out_check_next;
  logic          out_last, out_last_next;
  logic [RW-1:0] ser_rem, ser_rem_next;
  logic [CW-1:0] ser_cnt, ser_cnt_next;
  logic          load;

  assign {job_bit, job_last, job_r, job_rem} = job;
  assign load = ~out_valid | code_out.ready;

  // Next beat: pending check bit first, else the next queued job
  always_comb begin
    pop            = 1'b0;
    out_valid_next = out_valid;
    out_bit_next   = out_bit;
    out_check_next = out_check;
    out_last_next  = out_last;
    ser_rem_next   = ser_rem;
    ser_cnt_next   = ser_cnt;
    if (load) begin
      if (ser_cnt != '0) begin
        out_valid_next = 1'b1;
        out_bit_next   = ser_rem[RW-1];
        out_check_next = 1'b1;
        out_last_next  = (ser_cnt == CW'(1));
        ser_rem_next   = ser_rem << 1;
        ser_cnt_next   = ser_cnt - CW'(1);
      end else if (!empty) begin
        pop            = 1'b1;
        out_valid_next = 1'b1;
        out_bit_next   = job_bit;
        out_check_next = 1'b0;
        out_last_next  = 1'b0;
        if (job_last) begin
          // left-align so the check MSB sits at the top
          ser_rem_next = job_rem << (CW'(RW) - job_r);
          ser_cnt_next = job_r;
        end
      end else begin
        out_valid_next = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ser_cnt   <= '0;
    end else begin
      out_valid <= out_valid_next;
      ser_cnt   <= ser_cnt_next;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    out_bit   <= out_bit_next;
    out_check <= out_check_next;
    out_last  <= out_last_next;
    ser_rem   <= ser_rem_next;
  end

  assign code_out.valid     = out_valid;
  assign code_out.code_bit  = out_bit;
  assign code_out.is_check  = out_check;
  assign code_out.code_last = out_last;

endmodule

// File: sv/crc_codeword_generator_unit.sv
// Top level: bit-serial systematic CRC encoder with a programmable generator.
//
// Usage:
//   bit_in carries one message bit per beat (data_bit, MSB first) with msg_last
//   on the final bit. code_out carries the codeword: each message bit echoed
//   (is_check = 0), and after the final one, gen_length-1 check bits MSB first
//   (is_check = 1, gen_length clamped to 2..MAX_GEN_LEN), code_last on the last.
//   The user must write configuration (gen_poly_low_bits at index 0, gen_length
//   at index 1) via cfg_we/cfg_idx/cfg_data while the block is idle (unchecked).
// Timing:
//   A message bit is accepted every cycle while bit_in.ready is high; its echo
//   passes the job queue and the output register. A final bit costs 1 + gen_length-1
//   beats, one per cycle while code_out.ready is high, from the single serializer
//   output register; the two-entry job queue fills and bit_in.ready drops until it drains.
// Reset (rst, synchronous): remainder and queue clear, generator length goes
//   to 2 and the generator low bits to zero.
// Stall: when code_out.ready is low the output beat holds, the queue fills and
//   bit_in is back-pressured; nothing is dropped.
module crc_codeword_generator_unit import crc_cg_pkg::*; #(
  parameter int MAX_GEN_LEN = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  crc_cg_in_if.sink             bit_in,
  crc_cg_out_if.source          code_out
);

  localparam int RW = MAX_GEN_LEN - 1;
  localparam int CW = $clog2(MAX_GEN_LEN);
  localparam int JW = RW + CW + 2;

  logic          push;
  logic [JW-1:0] push_data;
  logic          full;
  logic          pop;
  logic [JW-1:0] pop_data;
  logic          empty;

  crc_cg_front #(.MAX_GEN_LEN(MAX_GEN_LEN)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .bit_in    (bit_in),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  crc_cg_fifo #(.W(JW)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  crc_cg_back #(.MAX_GEN_LEN(MAX_GEN_LEN)) u_back (
    .clk      (clk),
    .rst      (rst),
    .job      (pop_data),
    .empty    (empty),
    .pop      (pop),
    .code_out (code_out)
  );

endmodule
